// File: hw/rtl/rpme_pkg.sv
// Shared widths, constants and types of the RGB point material estimator.
package rpme_pkg;

    // Field widths.
    localparam int ColorW = 8;
    localparam int OutW   = 17;
    localparam int SumW   = 24;
    localparam int SqW    = 18;
    localparam int MsW    = 33;
    localparam int RootW  = 17;

    // Fixed-point one with 16 fraction bits.
    localparam logic [OutW-1:0] OneQ16 = OutW'(65536);

    // Grayscale weights, each set summing to one in Q16.
    localparam logic [15:0] WiRed   = 16'd19661;
    localparam logic [15:0] WiGreen = 16'd38666;
    localparam logic [15:0] WiBlue  = 16'd7209;
    localparam logic [15:0] WrRed   = 16'd13926;
    localparam logic [15:0] WrGreen = 16'd46885;
    localparam logic [15:0] WrBlue  = 16'd4725;

    // Division by 255 with rounding: estimate by 257/65536, then correct.
    localparam logic [7:0]  Div255     = 8'd255;
    localparam logic [6:0]  RoundBias  = 7'd127;
    localparam logic [8:0]  Div255Mul  = 9'd257;
    localparam int          Div255Shft = 16;

    // Mean square: floor(sq * 2^32 / 195075) = sq * MsA + floor(sq * MsB / 195075).
    localparam longint unsigned MsDivL   = 64'd195075;
    localparam int              MsShift  = 40;
    localparam logic [17:0]     MsDiv    = 18'(MsDivL);
    localparam logic [14:0]     MsA      = 15'((64'd1 << 32) / MsDivL);
    localparam logic [9:0]      MsB      = 10'((64'd1 << 32) % MsDivL);
    localparam logic [22:0]     MsRecip  = 23'((64'd1 << MsShift) / MsDivL);
    localparam int              MsYW     = 28;
    localparam int              MsQW     = 11;

    // Square root iterations for a radicand of MsW bits.
    localparam int NIter = 17;

    // Values carried alongside the square root.
    typedef struct packed {
        logic [OutW-1:0] intensity;
        logic [OutW-1:0] reflectance;
    } t_side;

endpackage

// File: hw/rtl/rpme_if.sv
// Stream interfaces for colour items in and material items out.
interface rpme_pix_if;
    import rpme_pkg::*;

    logic              valid;
    logic              ready;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rpme_mat_if;
    import rpme_pkg::*;

    logic            valid;
    logic            ready;
    logic [OutW-1:0] intensity;
    logic [OutW-1:0] reflectance;
    logic [OutW-1:0] albedo;
    logic [OutW-1:0] emissivity;

    modport source (output valid, output intensity, output reflectance, output albedo,
                    output emissivity, input ready);
    modport sink   (input valid, input intensity, input reflectance, input albedo,
                    input emissivity, output ready);
endinterface

// File: hw/rtl/rpme_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, two result bits per stage and one in the last.
module rpme_sqrt_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rpme_pkg::MsW-1:0]     i_rad,
    input  rpme_pkg::t_side              i_side,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rpme_pkg::RootW-1:0]   o_root,
    output rpme_pkg::t_side              o_side
);
    import rpme_pkg::*;

    localparam int RW = MsW + 1;
    localparam int NS = (NIter + 1) / 2;

    typedef struct packed {
        logic [RW-1:0] rad;
        logic [RW-1:0] res;
    } t_root;

    // One iteration: try to subtract res + 4^k from the remaining radicand.
    function automatic t_root root_step(input t_root cur, input int k);
        logic [RW-1:0] bit_v;
        logic [RW-1:0] trial;
        t_root         nxt;
        bit_v = RW'(1) << (2 * k);
        trial = cur.res + bit_v;
        if (cur.rad >= trial) begin
            nxt.rad = cur.rad - trial;
            nxt.res = (cur.res >> 1) + bit_v;
        end else begin
            nxt.rad = cur.rad;
            nxt.res = cur.res >> 1;
        end
        return nxt;
    endfunction

    logic [NS-1:0] r_vld;
    t_root         r_st   [NS];
    t_side         r_side [NS];
    t_root         n_st   [NS];
    t_root         w_prev [NS];
    t_side         w_sprev[NS];
    logic [NS-1:0] w_vprev;
    logic [NS:0]   w_en;

    // Inputs of each stage: the module input or the stage before.
    always_comb begin
        w_prev[0]  = '{rad: RW'(i_rad), res: '0};
        w_sprev[0] = i_side;
        w_vprev[0] = i_valid;
        for (int j = 1; j < NS; j++) begin
            w_prev[j]  = r_st[j-1];
            w_sprev[j] = r_side[j-1];
            w_vprev[j] = r_vld[j-1];
        end
    end

    // Two iterations per stage; the last stage does the final single one.
    always_comb begin
        t_root cur;
        for (int j = 0; j < NS; j++) begin
            cur = root_step(w_prev[j], NIter - 1 - 2 * j);
            if (2 * j + 1 < NIter) begin
                cur = root_step(cur, NIter - 2 - 2 * j);
            end
            n_st[j] = cur;
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_en[NS] = i_ready;
        for (int j = NS - 1; j >= 0; j--) begin
            w_en[j] = !r_vld[j] || w_en[j+1];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < NS; j++) begin
                if (w_en[j]) begin
                    r_vld[j] <= w_vprev[j];
                end
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NS; j++) begin
            if (w_en[j]) begin
                r_st[j]   <= n_st[j];
                r_side[j] <= w_sprev[j];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NS-1];
    assign o_root  = RootW'(r_st[NS-1].res);
    assign o_side  = r_side[NS-1];

`ifndef ASSERT_OFF
    // The finished root fits the result width.
    a_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> (r_st[NS-1].res[RW-1:RootW] == '0))
        else $error("square root exceeds its width");

    // The remainder of a floor square root never exceeds twice the root.
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> (r_st[NS-1].rad <= (r_st[NS-1].res << 1)))
        else $error("square root remainder too large");
`endif
endmodule

// File: hw/rtl/rgb_point_material_estimator.sv
// Top level of the RGB point material estimator pipeline.
//
//  Channel  Dir  Fields                                       Accepted when
//  i_pix    in   red, green, blue (8 bits each)               valid && ready
//  o_mat    out  intensity, reflectance, albedo, emissivity   valid && ready
//
// One item enters per cycle while the output is not stalled; each item passes
// four front stages for the weighted sums and the mean square, nine square
// root stages, and two stages for albedo.
// Reset clears only the valid bits of every stage.
// Each stage holds its item under a stall and empty stages keep filling, so
// bubbles close up and nothing is lost or repeated.
module rgb_point_material_estimator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpme_pix_if.sink   i_pix,
    rpme_mat_if.source o_mat
);
    import rpme_pkg::*;

    // Correct an estimate of t/255 that may be up to two low.
    function automatic logic [OutW-1:0] div255_fix(input logic [SumW-1:0] t,
                                                   input logic [OutW-1:0] q);
        logic [SumW-1:0] diff;
        logic [9:0]      rem;
        diff = t - SumW'(q) * SumW'(Div255);
        rem  = 10'(diff);
        if (rem >= 10'(2 * Div255)) begin
            return q + OutW'(2);
        end else if (rem >= 10'(Div255)) begin
            return q + OutW'(1);
        end
        return q;
    endfunction

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;
    logic                 w_en1, w_en2, w_en3, w_en4, w_en5, w_eno;
    logic [SumW-1:0]      r_si1, r_sr1, n_si1, n_sr1;
    logic [SqW-1:0]       r_sq1, n_sq1;
    logic [SumW-1:0]      r_ti2, r_tr2, n_ti2, n_tr2;
    logic [OutW-1:0]      r_qi2, r_qr2, n_qi2, n_qr2;
    logic [MsYW-1:0]      r_y2, n_y2, r_y3;
    logic [31:0]          r_pa2, n_pa2, r_pa3;
    logic [OutW-1:0]      r_int3, r_ref3, n_int3, n_ref3;
    logic [MsQW-1:0]      r_qm3, n_qm3;
    logic [MsW-1:0]       r_ms4, n_ms4;
    t_side                r_side4;
    logic [MsYW-1:0]      w_prod4, w_rem4;
    logic                 w_sq_valid, w_sq_ready;
    logic [RootW-1:0]     w_root;
    t_side                w_sq_side;
    logic [MsW-1:0]       r_prod5;
    t_side                r_side5;
    logic [OutW-1:0]      r_int_o, r_ref_o, r_alb_o, r_emi_o;

    // Stage enables: a stage moves when it is empty or its successor moves.
    assign w_eno = !r_vo || o_mat.ready;
    assign w_en5 = !r_v5 || w_eno;
    assign w_en4 = !r_v4 || w_sq_ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_pix.ready = w_en1;

    // Stage 1: weighted sums and sum of squares.
    always_comb begin
        n_si1 = SumW'(WiRed) * SumW'(i_pix.red) + SumW'(WiGreen) * SumW'(i_pix.green)
              + SumW'(WiBlue) * SumW'(i_pix.blue);
        n_sr1 = SumW'(WrRed) * SumW'(i_pix.red) + SumW'(WrGreen) * SumW'(i_pix.green)
              + SumW'(WrBlue) * SumW'(i_pix.blue);
        n_sq1 = SqW'(i_pix.red) * SqW'(i_pix.red) + SqW'(i_pix.green) * SqW'(i_pix.green)
              + SqW'(i_pix.blue) * SqW'(i_pix.blue);
    end

    // Stage 2: quotient estimates by 255, and the two parts of the mean square.
    always_comb begin
        n_ti2 = r_si1 + SumW'(RoundBias);
        n_tr2 = r_sr1 + SumW'(RoundBias);
        n_qi2 = OutW'((33'(n_ti2) * 33'(Div255Mul)) >> Div255Shft);
        n_qr2 = OutW'((33'(n_tr2) * 33'(Div255Mul)) >> Div255Shft);
        n_pa2 = 32'(r_sq1) * 32'(MsA);
        n_y2  = MsYW'(r_sq1) * MsYW'(MsB);
    end

    // Stage 3: exact rounded quotients; reciprocal estimate of y / 195075.
    always_comb begin
        n_int3 = div255_fix(r_ti2, r_qi2);
        n_ref3 = div255_fix(r_tr2, r_qr2);
        n_qm3  = MsQW'((51'(r_y2) * 51'(MsRecip)) >> MsShift);
    end

    // Stage 4: correct the estimate by one and assemble the mean square.
    always_comb begin
        w_prod4 = MsYW'(r_qm3) * MsYW'(MsDiv);
        w_rem4  = r_y3 - w_prod4;
        n_ms4   = MsW'(r_pa3) + MsW'(r_qm3) + MsW'(w_rem4 >= MsYW'(MsDiv));
    end

    // Valid bits of the front, albedo and output stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_pix.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= w_sq_valid;
            if (w_eno) r_vo <= r_v5;
        end
    end

    // Front stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_si1 <= n_si1;
            r_sr1 <= n_sr1;
            r_sq1 <= n_sq1;
        end
        if (w_en2) begin
            r_ti2 <= n_ti2;
            r_tr2 <= n_tr2;
            r_qi2 <= n_qi2;
            r_qr2 <= n_qr2;
            r_pa2 <= n_pa2;
            r_y2  <= n_y2;
        end
        if (w_en3) begin
            r_int3 <= n_int3;
            r_ref3 <= n_ref3;
            r_qm3  <= n_qm3;
            r_pa3  <= r_pa2;
            r_y3   <= r_y2;
        end
        if (w_en4) begin
            r_ms4               <= n_ms4;
            r_side4.intensity   <= r_int3;
            r_side4.reflectance <= r_ref3;
        end
    end

    // Root of the mean square.
    rpme_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (w_sq_ready),
        .i_rad   (r_ms4),
        .i_side  (r_side4),
        .o_valid (w_sq_valid),
        .i_ready (w_en5),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Albedo product, then rounding and the output register.
    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_prod5 <= MsW'(w_root) * MsW'(w_sq_side.intensity);
            r_side5 <= w_sq_side;
        end
        if (w_eno) begin
            r_int_o <= r_side5.intensity;
            r_ref_o <= r_side5.reflectance;
            r_alb_o <= OutW'((r_prod5 + MsW'(32768)) >> 16);
            r_emi_o <= OneQ16 - r_side5.intensity;
        end
    end

    assign o_mat.valid       = r_vo;
    assign o_mat.intensity   = r_int_o;
    assign o_mat.reflectance = r_ref_o;
    assign o_mat.albedo      = r_alb_o;
    assign o_mat.emissivity  = r_emi_o;

`ifndef ASSERT_OFF
    // Rounded intensity never exceeds one.
    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_int3 <= OneQ16))
        else $error("intensity out of range");

    // Mean square never exceeds 2^32.
    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_ms4 <= (MsW'(1) << 32)))
        else $error("mean square out of range");

    // Emissivity complements intensity, and albedo cannot exceed intensity.
    a_out_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ((18'(r_int_o) + 18'(r_emi_o) == 18'(OneQ16)) && (r_alb_o <= r_int_o)))
        else $error("output item inconsistent");
`endif
endmodule

// File: verif/rgb_point_material_estimator_tb.sv
// Self-checking testbench for the RGB point material estimator pipeline.
module rgb_point_material_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpme_pkg::*;

    // Weights of the two grayscale sums, each set adding up to one in Q16.
    localparam longint unsigned GreyWR = 19661;
    localparam longint unsigned GreyWG = 38666;
    localparam longint unsigned GreyWB = 7209;
    localparam longint unsigned LumaWR = 13926;
    localparam longint unsigned LumaWG = 46885;
    localparam longint unsigned LumaWB = 4725;
    localparam longint unsigned UnitQ16 = 65536;
    // Three channels at full scale squared.
    localparam longint unsigned FullSq = 195075;

    localparam int RandomPoints = 1450;
    localparam int SettleCycles = 40;
    localparam int HoldOffAt    = 500;
    localparam int HoldOffLen   = 300;

    typedef struct {
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
        int                idle_before;
        bit                drain_first;
    } point_colour_t;

    typedef struct {
        logic [OutW-1:0] intensity;
        logic [OutW-1:0] reflectance;
        logic [OutW-1:0] albedo;
        logic [OutW-1:0] emissivity;
    } material_t;

    logic i_clk;
    logic i_rst_n;

    rpme_pix_if pix_ch ();
    rpme_mat_if mat_ch ();

    rgb_point_material_estimator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_mat   (mat_ch)
    );

    point_colour_t colour_queue[$];
    material_t     material_due[$];
    point_colour_t next_pt;
    material_t     got_mat;
    material_t     want_mat;
    int            n_errors;
    int            n_taken;
    int            sink_gap;
    int            sink_calm;
    int            hold_cycles;
    bit            hold_done;

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Floor of the square root, one result bit at a time from the top.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = 16; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Weighted sum divided by 255, rounded to nearest.
    function automatic longint unsigned weighted_q16(
        longint unsigned r, longint unsigned g, longint unsigned b,
        longint unsigned wr, longint unsigned wg, longint unsigned wb);
        return (wr * r + wg * g + wb * b + 127) / 255;
    endfunction

    // Material values that one colour should produce.
    function automatic material_t material_of(logic [ColorW-1:0] r, logic [ColorW-1:0] g,
                                              logic [ColorW-1:0] b);
        material_t       m;
        longint unsigned lr;
        longint unsigned lg;
        longint unsigned lb;
        longint unsigned grey;
        longint unsigned luma;
        longint unsigned rms;
        lr   = r;
        lg   = g;
        lb   = b;
        grey = weighted_q16(lr, lg, lb, GreyWR, GreyWG, GreyWB);
        luma = weighted_q16(lr, lg, lb, LumaWR, LumaWG, LumaWB);
        rms  = root_floor(((lr * lr + lg * lg + lb * lb) << 32) / FullSq);
        m.intensity   = OutW'(grey);
        m.reflectance = OutW'(luma);
        m.albedo      = OutW'((rms * grey + 32768) >> 16);
        m.emissivity  = OutW'(UnitQ16 - grey);
        return m;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Channel value with extra weight on the ends of the range.
    function automatic logic [ColorW-1:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return ColorW'($urandom_range(0, 3));
            3: return ColorW'($urandom_range(252, 255));
            default: return ColorW'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_point(logic [ColorW-1:0] r, logic [ColorW-1:0] g,
                               logic [ColorW-1:0] b, int idle, bit drain);
        point_colour_t p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.idle_before = idle;
        p.drain_first = drain;
        colour_queue.push_back(p);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Driver: offers queued colours, holds an item until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                material_due.push_back(material_of(pix_ch.red, pix_ch.green, pix_ch.blue));
                n_taken <= n_taken + 1;
            end
            if (pix_ch.valid && !pix_ch.ready) begin
                // Item still waiting; keep it on the bus.
            end else if (colour_queue.size() == 0) begin
                pix_ch.valid <= 1'b0;
            end else if (colour_queue[0].idle_before > 0) begin
                colour_queue[0].idle_before--;
                pix_ch.valid <= 1'b0;
            end else if (colour_queue[0].drain_first && material_due.size() != 0) begin
                pix_ch.valid <= 1'b0;
            end else begin
                next_pt = colour_queue.pop_front();
                pix_ch.valid <= 1'b1;
                pix_ch.red   <= next_pt.red;
                pix_ch.green <= next_pt.green;
                pix_ch.blue  <= next_pt.blue;
            end
        end
    end

    // Long hold-off of the output, started once the pipeline has seen enough items.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && n_taken >= HoldOffAt) begin
            hold_cycles <= HoldOffLen;
            hold_done   <= 1'b1;
        end
    end

    // Monitor: checks each result item against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mat_ch.ready <= 1'b0;
        end else begin
            if (mat_ch.valid && mat_ch.ready) begin
                got_mat.intensity   = mat_ch.intensity;
                got_mat.reflectance = mat_ch.reflectance;
                got_mat.albedo      = mat_ch.albedo;
                got_mat.emissivity  = mat_ch.emissivity;
                if (material_due.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want_mat = material_due.pop_front();
                    if (got_mat.intensity !== want_mat.intensity)
                        report_mismatch($sformatf("intensity %0d, expected %0d",
                                        got_mat.intensity, want_mat.intensity));
                    if (got_mat.reflectance !== want_mat.reflectance)
                        report_mismatch($sformatf("reflectance %0d, expected %0d",
                                        got_mat.reflectance, want_mat.reflectance));
                    if (got_mat.albedo !== want_mat.albedo)
                        report_mismatch($sformatf("albedo %0d, expected %0d",
                                        got_mat.albedo, want_mat.albedo));
                    if (got_mat.emissivity !== want_mat.emissivity)
                        report_mismatch($sformatf("emissivity %0d, expected %0d",
                                        got_mat.emissivity, want_mat.emissivity));
                end
            end
            // Calm stretches with the output always ready.
            if (sink_calm > 0) begin
                sink_calm <= sink_calm - 1;
            end else if ($urandom_range(0, 149) == 0) begin
                sink_calm <= $urandom_range(50, 150);
            end
            if (hold_cycles > 0) begin
                mat_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                mat_ch.ready <= 1'b0;
            end else begin
                mat_ch.ready <= 1'b1;
                sink_gap = (sink_calm > 0) ? 0 : pick_idle();
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        bit calm;
        int i;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        mat_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_errors     = 0;
        n_taken      = 0;
        sink_gap     = 0;
        sink_calm    = 0;
        hold_cycles  = 0;
        hold_done    = 1'b0;
        calm         = 1'b0;

        // Black, full white, single channels at both ends, bit patterns, greys and two-channel mixes.
        queue_point(8'd0,   8'd0,   8'd0,   0, 1'b0);
        queue_point(8'd255, 8'd255, 8'd255, 0, 1'b0);
        queue_point(8'd255, 8'd0,   8'd0,   0, 1'b0);
        queue_point(8'd0,   8'd255, 8'd0,   0, 1'b0);
        queue_point(8'd0,   8'd0,   8'd255, 1, 1'b0);
        queue_point(8'd1,   8'd0,   8'd0,   0, 1'b0);
        queue_point(8'd0,   8'd1,   8'd0,   2, 1'b0);
        queue_point(8'd0,   8'd0,   8'd1,   0, 1'b0);
        queue_point(8'd1,   8'd1,   8'd1,   0, 1'b0);
        queue_point(8'd170, 8'd85,  8'd170, 3, 1'b0);
        queue_point(8'd85,  8'd170, 8'd85,  0, 1'b0);
        queue_point(8'd254, 8'd254, 8'd254, 0, 1'b0);
        queue_point(8'd128, 8'd128, 8'd128, 0, 1'b0);
        queue_point(8'd255, 8'd255, 8'd0,   0, 1'b0);
        queue_point(8'd0,   8'd255, 8'd255, 0, 1'b0);
        queue_point(8'd255, 8'd0,   8'd255, 0, 1'b0);

        // Random colours in blocks of 50, some blocks without any idling;
        // a few items wait for the pipeline to empty first.
        for (i = 0; i < RandomPoints; i++) begin
            if (i % 50 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            queue_point(pick_channel(), pick_channel(), pick_channel(),
                        calm ? 0 : pick_idle(),
                        (i == 300) || (i == 800) || (i == 1200));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (colour_queue.size() != 0 || pix_ch.valid) @(posedge i_clk);
        while (material_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);

        if (material_due.size() != 0) begin
            report_mismatch($sformatf("%0d result items never arrived", material_due.size()));
        end
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #1_500_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
